/* hdl/ultrasonic_ranging_controller_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the ultrasonic ranging controller
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_RANGING_CONTROLLER_ASSERT_SVH
`define ULTRASONIC_RANGING_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define URC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ranging controller check failed");

// The consequent must hold in the cycle after the antecedent.
`define URC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ranging controller check failed");

`endif

/* hdl/urc_pkg.sv */
// ----------------------------------------------------------------------------
// urc_pkg
// Types and constants shared by the ultrasonic ranging controller.
// ----------------------------------------------------------------------------
package urc_pkg;

   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_TRIG = 2'd1,
      PHASE_ECHO = 2'd2
   } phase_type;

   // Event codes on the request channel.
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_EDGE  = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_ECHO_TIMEOUT = 2'd0;
   localparam logic [1:0] CSR_WATCHDOG     = 2'd1;
   localparam logic [1:0] CSR_ACCEPT_LIMIT = 2'd2;

   localparam logic [11:0] ECHO_TIMEOUT_RESET = 12'd3900;
   localparam logic [15:0] WATCHDOG_RESET     = 16'd50000;
   localparam logic [7:0]  ACCEPT_LIMIT_RESET = 8'd20;

   // Distance = count * 0.1715 in unsigned Q0.16.
   localparam logic [13:0] DIST_MUL   = 14'd11239;
   localparam int          DIST_SHIFT = 16;

   localparam logic [7:0] DISP_LOW      = 8'd4;
   localparam logic [4:0] DISP_LOW_OUT  = 5'd3;
   localparam logic [7:0] DISP_HIGH     = 8'd15;
   localparam logic [4:0] DISP_HIGH_OUT = 5'd16;

   typedef struct packed {
      phase_type   phase;
      logic [1:0]  pulse_step;
      logic [12:0] echo_count;
      logic [16:0] watchdog_count;
      logic [7:0]  accepted_distance;
      logic        report_pending;
      logic        trigger_out;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:             PHASE_IDLE,
      pulse_step:        2'd0,
      echo_count:        13'd0,
      watchdog_count:    17'd0,
      accepted_distance: 8'd0,
      report_pending:    1'b0,
      trigger_out:       1'b0
   };

   typedef struct packed {
      logic [11:0] echo_timeout_ticks;
      logic [15:0] watchdog_ticks;
      logic [7:0]  distance_accept_limit;
   } cfg_type;

   typedef struct packed {
      logic       trigger_level;
      logic       distance_done;
      logic [7:0] distance_value;
      logic [4:0] display_value;
      logic [1:0] phase_now;
   } result_type;

endpackage

/* hdl/urc_step.sv */
// ----------------------------------------------------------------------------
// urc_step
// Next-state and result logic for one event of the ranging controller.
// ----------------------------------------------------------------------------
module urc_step (
   input  urc_pkg::state_type  cur_state,
   input  urc_pkg::cfg_type    cfg,
   input  logic [1:0]          opcode,
   input  logic                echo_level,
   output urc_pkg::state_type  nxt_state,
   output urc_pkg::result_type result
);

   logic [12:0] count_inc;
   logic [12:0] finish_count;
   logic [26:0] product;
   logic [10:0] distance;
   logic        distance_ok;
   logic [16:0] watchdog_base;
   logic        done;

   assign count_inc = cur_state.echo_count + 13'd1;
   // A falling edge ends on the current count, a timeout on the incremented one.
   assign finish_count = (opcode == urc_pkg::OP_EDGE) ? cur_state.echo_count : count_inc;
   assign product = 27'(finish_count) * 27'(urc_pkg::DIST_MUL);
   assign distance = product[urc_pkg::DIST_SHIFT +: 11];
   assign distance_ok = distance < {3'b000, cfg.distance_accept_limit};

   always_comb begin
      nxt_state = cur_state;
      done = 1'b0;
      watchdog_base = cur_state.watchdog_count;
      unique case (opcode)
         urc_pkg::OP_TICK: begin
            done = cur_state.report_pending;
            nxt_state.report_pending = 1'b0;
            if (cur_state.phase == urc_pkg::PHASE_TRIG) begin
               unique case (cur_state.pulse_step)
                  2'd0: nxt_state.pulse_step = 2'd1;
                  2'd1: begin
                     nxt_state.trigger_out = 1'b1;
                     nxt_state.pulse_step = 2'd2;
                  end
                  2'd2: begin
                     nxt_state.trigger_out = 1'b0;
                     nxt_state.pulse_step = 2'd3;
                  end
                  2'd3: ;
               endcase
            end else if (cur_state.phase == urc_pkg::PHASE_ECHO) begin
               nxt_state.echo_count = count_inc;
               if (count_inc > {1'b0, cfg.echo_timeout_ticks}) begin
                  if (distance_ok) begin
                     nxt_state.accepted_distance = distance[7:0];
                  end
                  watchdog_base = 17'd0;
                  nxt_state.report_pending = 1'b1;
                  nxt_state.phase = urc_pkg::PHASE_IDLE;
               end
            end
            // The timeout path clears the watchdog and then still counts this tick.
            if (cur_state.phase != urc_pkg::PHASE_IDLE) begin
               nxt_state.watchdog_count = watchdog_base + 17'd1;
            end
            if (nxt_state.watchdog_count > {1'b0, cfg.watchdog_ticks}) begin
               nxt_state.watchdog_count = 17'd0;
               nxt_state.phase = urc_pkg::PHASE_IDLE;
            end
         end
         urc_pkg::OP_START: begin
            if (cur_state.phase == urc_pkg::PHASE_IDLE) begin
               nxt_state.pulse_step = 2'd0;
               nxt_state.phase = urc_pkg::PHASE_TRIG;
            end
         end
         urc_pkg::OP_EDGE: begin
            if (cur_state.phase == urc_pkg::PHASE_TRIG && echo_level) begin
               nxt_state.echo_count = 13'd0;
               nxt_state.phase = urc_pkg::PHASE_ECHO;
            end else if (cur_state.phase == urc_pkg::PHASE_ECHO && !echo_level) begin
               if (distance_ok) begin
                  nxt_state.accepted_distance = distance[7:0];
               end
               nxt_state.watchdog_count = 17'd0;
               nxt_state.report_pending = 1'b1;
               nxt_state.phase = urc_pkg::PHASE_IDLE;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      result.trigger_level = nxt_state.trigger_out;
      result.distance_done = done;
      result.distance_value = nxt_state.accepted_distance;
      result.phase_now = nxt_state.phase;
      priority if (nxt_state.accepted_distance < urc_pkg::DISP_LOW) begin
         result.display_value = urc_pkg::DISP_LOW_OUT;
      end else if (nxt_state.accepted_distance > urc_pkg::DISP_HIGH) begin
         result.display_value = urc_pkg::DISP_HIGH_OUT;
      end else begin
         result.display_value = nxt_state.accepted_distance[4:0];
      end
   end

endmodule

/* hdl/ultrasonic_ranging_controller.sv */
// ----------------------------------------------------------------------------
// Ultrasonic ranging controller
// Trigger/echo sensor sequencer with tick-based echo timing and distance latch.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  req_     in         tdata: opcode [1:0], echo_level [2]
//  rsp_     out        tdata: trigger, done, distance, display, phase
//  csr_     in         write enable, register index, write data
//
//  The state registers update at each transfer and the result is registered,
//  so one event is taken every clock while req_tready is high. The path is set
//  by the 13 x 14 bit distance multiplier feeding the accept compare. A two-entry
//  output stage (result register plus skid) lowers req_tready only while the skid
//  is full. Reset is synchronous; it clears the state and valids, loads CSR defaults.
// ----------------------------------------------------------------------------
module ultrasonic_ranging_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [1:0] opcode, [2] echo_level, [7:3] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [0] trigger_level, [1] distance_done,
                                    // [9:2] distance_value, [14:10] display_value,
                                    // [16:15] phase_now, [23:17] zero
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   urc_pkg::state_type  state_ff;
   urc_pkg::state_type  state_in;
   urc_pkg::cfg_type    cfg_ff;
   urc_pkg::result_type step_result;
   urc_pkg::result_type out_ff, out_in;
   urc_pkg::result_type skid_ff, skid_in;
   logic                out_vld_ff, out_vld_in;
   logic                skid_vld_ff, skid_vld_in;
   logic                req_fire;
   logic                rsp_pop;

   urc_step u_step (
      .cur_state  (state_ff),
      .cfg        (cfg_ff),
      .opcode     (req_tdata[1:0]),
      .echo_level (req_tdata[2]),
      .nxt_state  (state_in),
      .result     (step_result)
   );

   assign req_tready = !skid_vld_ff;
   assign req_fire = req_tvalid && req_tready;
   assign rsp_pop = out_vld_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.echo_timeout_ticks <= urc_pkg::ECHO_TIMEOUT_RESET;
         cfg_ff.watchdog_ticks <= urc_pkg::WATCHDOG_RESET;
         cfg_ff.distance_accept_limit <= urc_pkg::ACCEPT_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            urc_pkg::CSR_ECHO_TIMEOUT: cfg_ff.echo_timeout_ticks <= csr_wdata[11:0];
            urc_pkg::CSR_WATCHDOG:     cfg_ff.watchdog_ticks <= csr_wdata;
            urc_pkg::CSR_ACCEPT_LIMIT: cfg_ff.distance_accept_limit <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= urc_pkg::STATE_RESET;
      end else if (req_fire) begin
         state_ff <= state_in;
      end
   end

   // A new result goes to the skid only when the result register is held.
   always_comb begin
      out_in = out_ff;
      skid_in = skid_ff;
      out_vld_in = out_vld_ff;
      skid_vld_in = skid_vld_ff;
      if (skid_vld_ff) begin
         if (rsp_pop) begin
            out_in = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (req_fire) begin
         if (!out_vld_ff || rsp_pop) begin
            out_in = step_result;
            out_vld_in = 1'b1;
         end else begin
            skid_in = step_result;
            skid_vld_in = 1'b1;
         end
      end else if (rsp_pop) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata = {7'd0, out_ff.phase_now, out_ff.display_value,
                       out_ff.distance_value, out_ff.distance_done, out_ff.trigger_level};

endmodule

/* hdl/urc_checker.sv */
// ----------------------------------------------------------------------------
// urc_checker
// Port-level checks for the ultrasonic ranging controller, bound to the top.
// ----------------------------------------------------------------------------
`include "ultrasonic_ranging_controller_assert.svh"

module urc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   logic [7:0] rsp_distance;
   logic [4:0] rsp_display;
   logic       display_in_range;
   logic       distance_in_window;

   assign rsp_distance = rsp_tdata[9:2];
   assign rsp_display = rsp_tdata[14:10];
   assign display_in_range = rsp_display >= urc_pkg::DISP_LOW_OUT &&
                             rsp_display <= urc_pkg::DISP_HIGH_OUT;
   assign distance_in_window = rsp_distance >= urc_pkg::DISP_LOW &&
                               rsp_distance <= urc_pkg::DISP_HIGH;

   // A held result keeps its valid and its data.
   `URC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // The input side only stalls when the output stage is full.
   `URC_ASSERT_SAME(a_stall_needs_result, clock, reset, !req_tready, rsp_tvalid)

   // The display value always lies inside its clamp range.
   `URC_ASSERT_SAME(a_display_range, clock, reset, rsp_tvalid, display_in_range)

   // Inside the clamp window the display shows the distance itself.
   `URC_ASSERT_SAME(a_display_track, clock, reset, rsp_tvalid && distance_in_window, rsp_display == rsp_distance[4:0])

endmodule

bind ultrasonic_ranging_controller urc_checker u_urc_checker (.*);

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ultrasonic ranging controller. A directed table
// covers the idle, trigger and echo phases and the ignored events. Random
// measurement cycles then run under several register settings and with
// stalls on either stream side. Typed table rows are checked against the table,
// the rest against a cycle-free model of the sequencer kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic       is_write;
      logic [1:0] code;       // opcode, or register index for a write
      logic [15:0] value;     // bit 0 is the echo level for an event
      logic       typed;
      urc_pkg::result_type want;
   } stim_row_type;

   localparam urc_pkg::result_type SEEN_IDLE  =
      '{1'b0, 1'b0, 8'd0, urc_pkg::DISP_LOW_OUT, urc_pkg::PHASE_IDLE};
   localparam urc_pkg::result_type SEEN_TRIG  =
      '{1'b0, 1'b0, 8'd0, urc_pkg::DISP_LOW_OUT, urc_pkg::PHASE_TRIG};
   localparam urc_pkg::result_type SEEN_TRIGH =
      '{1'b1, 1'b0, 8'd0, urc_pkg::DISP_LOW_OUT, urc_pkg::PHASE_TRIG};
   localparam urc_pkg::result_type SEEN_ECHOH =
      '{1'b1, 1'b0, 8'd0, urc_pkg::DISP_LOW_OUT, urc_pkg::PHASE_ECHO};
   localparam urc_pkg::result_type SEEN_IDLEH =
      '{1'b1, 1'b0, 8'd0, urc_pkg::DISP_LOW_OUT, urc_pkg::PHASE_IDLE};
   localparam urc_pkg::result_type SEEN_DONEH =
      '{1'b1, 1'b1, 8'd0, urc_pkg::DISP_LOW_OUT, urc_pkg::PHASE_IDLE};

   localparam int DIRECTED_ROWS = 29;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{1'b0, OP_UNUSED,          16'd1, 1'b1, SEEN_IDLE},
      '{1'b0, urc_pkg::OP_TICK,   16'd0, 1'b1, SEEN_IDLE},
      '{1'b0, urc_pkg::OP_EDGE,   16'd1, 1'b1, SEEN_IDLE},
      '{1'b0, urc_pkg::OP_START,  16'd0, 1'b1, SEEN_TRIG},
      '{1'b0, urc_pkg::OP_START,  16'd1, 1'b1, SEEN_TRIG},
      '{1'b0, urc_pkg::OP_EDGE,   16'd0, 1'b1, SEEN_TRIG},
      '{1'b0, urc_pkg::OP_TICK,   16'd0, 1'b1, SEEN_TRIG},
      '{1'b0, urc_pkg::OP_TICK,   16'd1, 1'b1, SEEN_TRIGH},
      // The echo rises while the trigger pin is still high.
      '{1'b0, urc_pkg::OP_EDGE,   16'd1, 1'b1, SEEN_ECHOH},
      '{1'b0, urc_pkg::OP_EDGE,   16'd1, 1'b1, SEEN_ECHOH},
      '{1'b0, urc_pkg::OP_TICK,   16'd0, 1'b1, SEEN_ECHOH},
      '{1'b0, urc_pkg::OP_TICK,   16'd0, 1'b1, SEEN_ECHOH},
      '{1'b0, urc_pkg::OP_EDGE,   16'd0, 1'b1, SEEN_IDLEH},
      '{1'b0, urc_pkg::OP_TICK,   16'd0, 1'b1, SEEN_DONEH},
      '{1'b1, urc_pkg::CSR_ECHO_TIMEOUT, 16'd1,     1'b0, '0},
      '{1'b1, urc_pkg::CSR_WATCHDOG,     16'd65535, 1'b0, '0},
      '{1'b1, urc_pkg::CSR_ACCEPT_LIMIT, 16'd1,     1'b0, '0},
      '{1'b0, urc_pkg::OP_START,  16'd0, 1'b0, '0},
      '{1'b0, urc_pkg::OP_TICK,   16'd0, 1'b0, '0},
      '{1'b0, urc_pkg::OP_TICK,   16'd0, 1'b0, '0},
      '{1'b0, urc_pkg::OP_TICK,   16'd1, 1'b0, '0},
      '{1'b0, urc_pkg::OP_EDGE,   16'd1, 1'b0, '0},
      // The second tick passes the echo timeout of one.
      '{1'b0, urc_pkg::OP_TICK,   16'd0, 1'b0, '0},
      '{1'b0, urc_pkg::OP_TICK,   16'd0, 1'b0, '0},
      '{1'b0, urc_pkg::OP_TICK,   16'd0, 1'b0, '0},
      '{1'b1, urc_pkg::CSR_WATCHDOG,     16'd0,     1'b0, '0},
      // A zero watchdog limit clears the count left behind by the timeout.
      '{1'b0, urc_pkg::OP_TICK,   16'd0, 1'b0, '0},
      '{1'b0, urc_pkg::OP_START,  16'd0, 1'b0, '0},
      '{1'b0, urc_pkg::OP_TICK,   16'd0, 1'b0, '0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   int send_idle_pct = 34;
   int recv_idle_pct = 81;
   int items_sent = 0;
   int failures = 0;
   int cycles = 0;

   urc_pkg::result_type readings_due [$];
   urc_pkg::result_type got;

   // Sequencer state and registers as the bench tracks them.
   urc_pkg::cfg_type   cfg_now = '{urc_pkg::ECHO_TIMEOUT_RESET, urc_pkg::WATCHDOG_RESET,
                                   urc_pkg::ACCEPT_LIMIT_RESET};
   urc_pkg::phase_type ph = urc_pkg::PHASE_IDLE;
   logic [1:0]  pstep = '0;
   logic [12:0] echo_ticks = '0;
   logic [16:0] busy_ticks = '0;
   logic [7:0]  kept_dist = '0;
   logic        report_due = 1'b0;
   logic        trig_pin = 1'b0;

   ultrasonic_ranging_controller u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic void close_measurement();
      logic [31:0] span;
      span = ({19'd0, echo_ticks} * {18'd0, urc_pkg::DIST_MUL}) >> urc_pkg::DIST_SHIFT;
      if (span < {24'd0, cfg_now.distance_accept_limit})
         kept_dist = span[7:0];
      busy_ticks = '0;
      report_due = 1'b1;
      ph = urc_pkg::PHASE_IDLE;
   endfunction

   task automatic predict_reading(input logic [1:0] op, input logic lvl,
                                  output urc_pkg::result_type r);
      r = '0;
      case (op)
         urc_pkg::OP_TICK: begin
            if (report_due) begin
               r.distance_done = 1'b1;
               report_due = 1'b0;
            end
            if (ph == urc_pkg::PHASE_TRIG) begin
               if (pstep == 2'd0) begin
                  pstep = 2'd1;
               end else if (pstep == 2'd1) begin
                  trig_pin = 1'b1;
                  pstep = 2'd2;
               end else if (pstep == 2'd2) begin
                  trig_pin = 1'b0;
                  pstep = 2'd3;
               end
               busy_ticks = busy_ticks + 17'd1;
            end else if (ph == urc_pkg::PHASE_ECHO) begin
               echo_ticks = echo_ticks + 13'd1;
               if (echo_ticks > {1'b0, cfg_now.echo_timeout_ticks})
                  close_measurement();
               // After a timeout this leaves the busy count at one.
               busy_ticks = busy_ticks + 17'd1;
            end
            if (busy_ticks > {1'b0, cfg_now.watchdog_ticks}) begin
               busy_ticks = '0;
               ph = urc_pkg::PHASE_IDLE;
            end
         end
         urc_pkg::OP_START: begin
            if (ph == urc_pkg::PHASE_IDLE) begin
               pstep = 2'd0;
               ph = urc_pkg::PHASE_TRIG;
            end
         end
         urc_pkg::OP_EDGE: begin
            if (ph == urc_pkg::PHASE_TRIG && lvl) begin
               echo_ticks = '0;
               ph = urc_pkg::PHASE_ECHO;
            end else if (ph == urc_pkg::PHASE_ECHO && !lvl) begin
               close_measurement();
            end
         end
         default: ;
      endcase
      if (kept_dist < urc_pkg::DISP_LOW)
         r.display_value = urc_pkg::DISP_LOW_OUT;
      else if (kept_dist > urc_pkg::DISP_HIGH)
         r.display_value = urc_pkg::DISP_HIGH_OUT;
      else
         r.display_value = kept_dist[4:0];
      r.trigger_level = trig_pin;
      r.distance_value = kept_dist;
      r.phase_now = ph;
   endtask

   task automatic log_failure(input string what, input urc_pkg::result_type want,
                              input urc_pkg::result_type seen);
      failures++;
      if (failures <= 10) begin
         $display("%s: expected trig %0d done %0d dist %0d disp %0d phase %0d",
                  what, want.trigger_level, want.distance_done, want.distance_value,
                  want.display_value, want.phase_now);
         $display("%s: got trig %0d done %0d dist %0d disp %0d phase %0d",
                  what, seen.trigger_level, seen.distance_done, seen.distance_value,
                  seen.display_value, seen.phase_now);
      end
   endtask

   // Reading side: random stalls, and each transfer is checked in order.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.trigger_level  = rsp_tdata[0];
            got.distance_done  = rsp_tdata[1];
            got.distance_value = rsp_tdata[9:2];
            got.display_value  = rsp_tdata[14:10];
            got.phase_now      = rsp_tdata[16:15];
            if (readings_due.size() == 0)
               log_failure("unexpected reading", '0, got);
            else if (got !== readings_due[0])
               log_failure("reading mismatch", readings_due.pop_front(), got);
            else
               void'(readings_due.pop_front());
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_item(input logic [1:0] op, input logic lvl, input logic typed,
                            input urc_pkg::result_type want);
      urc_pkg::result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'd0, lvl, op};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predict_reading(op, lvl, predicted);
      readings_due.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   // Registers change only once every reading in flight has come back.
   task automatic write_register(input logic [1:0] idx, input logic [15:0] val);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (readings_due.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         urc_pkg::CSR_ECHO_TIMEOUT: cfg_now.echo_timeout_ticks = val[11:0];
         urc_pkg::CSR_WATCHDOG:     cfg_now.watchdog_ticks = val;
         urc_pkg::CSR_ACCEPT_LIMIT: cfg_now.distance_accept_limit = val[7:0];
         default: ;
      endcase
   endtask

   task automatic run_random(input int target);
      int first;
      int echo_len;
      first = items_sent;
      while (items_sent - first < target) begin
         if ($urandom_range(9) < 8) begin
            // A full measurement cycle with a few stray events mixed in.
            send_item(urc_pkg::OP_START, 1'($urandom_range(1)), 1'b0, '0);
            repeat ($urandom_range(4))
               send_item(urc_pkg::OP_TICK, 1'($urandom_range(1)), 1'b0, '0);
            send_item(urc_pkg::OP_EDGE, 1'b1, 1'b0, '0);
            echo_len = ($urandom_range(7) == 0) ? $urandom_range(200, 80)
                                                : $urandom_range(40);
            repeat (echo_len) begin
               if ($urandom_range(19) == 0)
                  send_item(2'($urandom_range(3)), 1'($urandom_range(1)), 1'b0, '0);
               send_item(urc_pkg::OP_TICK, 1'($urandom_range(1)), 1'b0, '0);
            end
            send_item(urc_pkg::OP_EDGE, 1'b0, 1'b0, '0);
            repeat ($urandom_range(2, 1))
               send_item(urc_pkg::OP_TICK, 1'($urandom_range(1)), 1'b0, '0);
         end else begin
            repeat ($urandom_range(5, 1))
               send_item(2'($urandom_range(3)), 1'($urandom_range(1)), 1'b0, '0);
         end
      end
   endtask

   initial begin
      logic [15:0] tmo_set   [7];
      logic [15:0] wdog_set  [7];
      logic [15:0] limit_set [7];
      tmo_set   = '{16'd4095,  16'd1, 16'd30,  16'd100, 16'd0, 16'd0, 16'd3900};
      wdog_set  = '{16'd65535, 16'd1, 16'd200, 16'd60,  16'd0, 16'd0, 16'd50000};
      limit_set = '{16'd255,   16'd1, 16'd20,  16'd10,  16'd0, 16'd0, 16'd20};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (DIRECTED[i].is_write)
            write_register(DIRECTED[i].code, DIRECTED[i].value);
         else
            send_item(DIRECTED[i].code, DIRECTED[i].value[0], DIRECTED[i].typed,
                      DIRECTED[i].want);
      end

      for (int p = 0; p < 7; p++) begin
         if (p < 2) begin
            send_idle_pct = 34;
            recv_idle_pct = 81;
         end else if (p < 4) begin
            send_idle_pct = 81;
            recv_idle_pct = 34;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (p == 5) begin
            tmo_set[p]   = 16'($urandom_range(200, 1));
            wdog_set[p]  = 16'($urandom_range(300, 5));
            limit_set[p] = 16'($urandom_range(255, 1));
         end
         write_register(urc_pkg::CSR_ECHO_TIMEOUT, tmo_set[p]);
         write_register(urc_pkg::CSR_WATCHDOG, wdog_set[p]);
         write_register(urc_pkg::CSR_ACCEPT_LIMIT, limit_set[p]);
         // A measurement cycle can run past the target, so the target is kept short.
         run_random(55);
      end

      req_tvalid <= 1'b0;
      while (readings_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (failures == 0 && readings_due.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
